[rtl/edv_pkg.sv]
`default_nettype none

package edv_pkg;

   // Operand width; the quotient carries one more bit.
   localparam int unsigned DataWidth = 32;
   localparam int unsigned QuoWidth  = DataWidth + 1;

   // Number of division cells, one per bit of the quotient magnitude.
   localparam int unsigned NumCells  = DataWidth;

   // One word on the request channel.
   typedef struct packed {
      logic signed [DataWidth-1:0] dividend;
      logic signed [DataWidth-1:0] divisor;
   } req_type;

   // One word on the response channel.
   typedef struct packed {
      logic signed [QuoWidth-1:0] quotient;
      logic                       divide_by_zero;
   } rsp_type;

   // Working state handed from cell to cell.
   // quo_dvd holds the dividend magnitude, shifted left one bit per cell,
   // while the quotient bits fill in from the bottom.
   typedef struct packed {
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo_dvd;
      logic [DataWidth-1:0] dvs;
      logic                 a_neg;
      logic                 b_neg;
      logic                 dbz;
   } stage_type;

endpackage

`default_nettype wire

[rtl/edv_front.sv]
`default_nettype none

module edv_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire edv_pkg::req_type  req_data,
   output logic                   valid_out,
   input  wire logic              ready_in,
   output edv_pkg::stage_type     stage_out
);

   logic                  valid_ff;
   edv_pkg::stage_type    stage_ff;
   edv_pkg::stage_type    stage_in;
   logic                  take;

   // Take a new word whenever this stage is empty or drains this cycle.
   assign req_ready = !valid_ff || ready_in;
   assign take      = req_valid && req_ready;

   // Split the operands into sign and magnitude.
   always_comb begin
      stage_in.a_neg   = req_data.dividend[edv_pkg::DataWidth-1];
      stage_in.b_neg   = req_data.divisor[edv_pkg::DataWidth-1];
      stage_in.quo_dvd = stage_in.a_neg ? (~req_data.dividend + 1'b1) : req_data.dividend;
      stage_in.dvs     = stage_in.b_neg ? (~req_data.divisor + 1'b1) : req_data.divisor;
      stage_in.rem     = '0;
      stage_in.dbz     = (req_data.divisor == '0);
   end

   // Occupancy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

`default_nettype wire

[rtl/edv_cell.sv]
`default_nettype none

module edv_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                valid_in,
   output logic                     ready_out,
   input  wire edv_pkg::stage_type  stage_in,
   output logic                     valid_out,
   input  wire logic                ready_in,
   output edv_pkg::stage_type       stage_out
);

   logic                       valid_ff;
   edv_pkg::stage_type         stage_ff;
   edv_pkg::stage_type         step;
   logic [edv_pkg::DataWidth:0] trial;
   logic [edv_pkg::DataWidth:0] diff;
   logic                       fits;

   assign ready_out = !valid_ff || ready_in;

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial        = {stage_in.rem, stage_in.quo_dvd[edv_pkg::DataWidth-1]};
      diff         = trial - {1'b0, stage_in.dvs};
      fits         = (trial >= {1'b0, stage_in.dvs});
      step         = stage_in;
      step.rem     = fits ? diff[edv_pkg::DataWidth-1:0] : trial[edv_pkg::DataWidth-1:0];
      step.quo_dvd = {stage_in.quo_dvd[edv_pkg::DataWidth-2:0], fits};
   end

   // Occupancy flag; a bubble is squeezed out when the next cell is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         stage_ff <= step;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

   // A held word must not change while the next cell is full.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !ready_in |=> valid_ff && $stable(stage_ff))
      else $error("edv_cell: held word changed under stall");

   // The partial remainder stays below the divisor in every valid non-zero-divisor word.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !stage_ff.dbz |-> stage_ff.rem < stage_ff.dvs)
      else $error("edv_cell: partial remainder not below divisor");

   // Reset empties the cell.
   assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("edv_cell: cell not empty after reset");

endmodule

`default_nettype wire

[rtl/edv_back.sv]
`default_nettype none

module edv_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                valid_in,
   output logic                     ready_out,
   input  wire edv_pkg::stage_type  stage_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output edv_pkg::rsp_type         rsp_data
);

   logic                             rsp_valid_ff;
   edv_pkg::rsp_type                 rsp_data_ff;
   edv_pkg::rsp_type                 rsp_data_in;
   logic [edv_pkg::QuoWidth-1:0]     ext;
   logic                             inc;
   logic                             q_neg;

   assign ready_out = !rsp_valid_ff || rsp_ready;

   // Euclidean fixup: a negative dividend with a remainder rounds the magnitude
   // up by one. Negating q+1 is just the complement of q, so one adder suffices.
   always_comb begin
      ext   = {1'b0, stage_in.quo_dvd};
      inc   = stage_in.a_neg && (stage_in.rem != '0);
      q_neg = stage_in.a_neg ^ stage_in.b_neg;
      rsp_data_in.divide_by_zero = stage_in.dbz;
      if (stage_in.dbz) begin
         rsp_data_in.quotient = '0;
      end else if (q_neg) begin
         rsp_data_in.quotient = inc ? ~ext : (~ext + 1'b1);
      end else begin
         rsp_data_in.quotient = ext + {{(edv_pkg::QuoWidth-1){1'b0}}, inc};
      end
   end

   // Output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_out) begin
         rsp_valid_ff <= valid_in;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/euclidean_integer_divider_top.sv]
// Euclidean integer divider, signed 32-bit operands, 33-bit quotient.
// Request channel: req_valid / req_ready carry one word holding the
// dividend and the divisor. Response channel: rsp_valid / rsp_ready carry
// one word holding the quotient and the divide_by_zero flag, in request order.
// The quotient is the one whose remainder is never negative; a zero divisor
// returns a quotient of 0 with divide_by_zero set.
// Through an empty pipe a word passes one sign/magnitude stage,
// a chain of 32 division cells that each produce one quotient bit, and one
// fixup stage that drives the output register.
// Throughput is one word per cycle when not stalled; each stage holds one word.
// When the receiver stalls, words stack up stage by stage behind the output
// register; empty stages still take new words, so req_ready drops only once
// the whole chain is full.
// Reset (synchronous, active high) empties every stage; words in flight are
// dropped and rsp_valid is low on the cycle after reset.
`default_nettype none

module euclidean_integer_divider_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire edv_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output edv_pkg::rsp_type       rsp_data
);

   // Index 0 is the front stage output; index k+1 is cell k's output.
   logic               chain_valid [edv_pkg::NumCells+1];
   logic               chain_ready [edv_pkg::NumCells+1];
   edv_pkg::stage_type chain_stage [edv_pkg::NumCells+1];

   // Sign and magnitude stage.
   edv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .valid_out (chain_valid[0]),
      .ready_in  (chain_ready[0]),
      .stage_out (chain_stage[0])
   );

   // Chain of division cells, one quotient bit each.
   for (genvar k = 0; k < edv_pkg::NumCells; k++) begin : g_cell
      edv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[k]),
         .ready_out (chain_ready[k]),
         .stage_in  (chain_stage[k]),
         .valid_out (chain_valid[k+1]),
         .ready_in  (chain_ready[k+1]),
         .stage_out (chain_stage[k+1])
      );
   end

   // Sign fixup and output register.
   edv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (chain_valid[edv_pkg::NumCells]),
      .ready_out (chain_ready[edv_pkg::NumCells]),
      .stage_in  (chain_stage[edv_pkg::NumCells]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [edv_pkg::DataWidth-1:0] OpMin =
      {1'b1, {(edv_pkg::DataWidth-1){1'b0}}};
   localparam logic signed [edv_pkg::DataWidth-1:0] OpMax = ~OpMin;
   localparam int RandomWords = 1500;
   localparam int DrainCycles = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   edv_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   edv_pkg::rsp_type rsp_data;

   edv_pkg::req_type pending_words[$];
   edv_pkg::rsp_type expected_quotients[$];
   int      total_words = 0;
   int      words_accepted = 0;
   int      mismatch_count = 0;
   bit      req_taken = 1'b0;

   euclidean_integer_divider_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Euclidean quotient: divide magnitudes, then round away from zero when a
   // negative dividend leaves a remainder, so the remainder stays nonnegative.
   function automatic edv_pkg::rsp_type euclid_quotient(edv_pkg::req_type w);
      logic [edv_pkg::DataWidth:0] mag_a;
      logic [edv_pkg::DataWidth:0] mag_b;
      logic [edv_pkg::DataWidth:0] quo;
      logic [edv_pkg::DataWidth:0] rmd;
      logic [edv_pkg::DataWidth:0] mag;
      bit                          neg_a;
      bit                          neg_b;
      bit                          neg_q;
      edv_pkg::rsp_type            res;
      neg_a = w.dividend[edv_pkg::DataWidth-1];
      neg_b = w.divisor[edv_pkg::DataWidth-1];
      mag_a = neg_a ? ({1'b0, ~w.dividend} + 1'b1) : {1'b0, w.dividend};
      mag_b = neg_b ? ({1'b0, ~w.divisor} + 1'b1) : {1'b0, w.divisor};
      res = '0;
      if (mag_b == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      quo = mag_a / mag_b;
      rmd = mag_a % mag_b;
      mag = (neg_a && rmd != '0) ? quo + 1'b1 : quo;
      neg_q = neg_a ? !neg_b : neg_b;
      res.quotient = neg_q ? (~mag + 1'b1) : mag;
      return res;
   endfunction

   // Idle length: mostly none or short, now and then a long one.
   function automatic int draw_gap(bit steady);
      int sel;
      sel = $urandom_range(0, 99);
      if (steady || sel < 55) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Operand with a spread of magnitudes, edges and full-range values.
   function automatic logic signed [edv_pkg::DataWidth-1:0] draw_operand(bit allow_zero);
      logic signed [edv_pkg::DataWidth-1:0] v;
      v = $urandom();
      case ($urandom_range(0, 11))
         0, 1, 2, 3: ;
         4, 5: begin
            v = $urandom_range(0, 40);
            v = v - 20;
         end
         6: begin
            case ($urandom_range(0, 4))
               0: v = OpMin;
               1: v = OpMax;
               2: v = 1;
               3: v = -1;
               default: v = OpMin + 1;
            endcase
         end
         7, 8, 9: v = v >>> $urandom_range(1, edv_pkg::DataWidth - 2);
         10: if (allow_zero) v = '0;
         default: v = $urandom_range(1, 9);
      endcase
      if (!allow_zero && v == '0) v = 1;
      return v;
   endfunction

   function automatic edv_pkg::req_type make_word(logic signed [edv_pkg::DataWidth-1:0] a,
                                                  logic signed [edv_pkg::DataWidth-1:0] b);
      edv_pkg::req_type w;
      w.dividend = a;
      w.divisor  = b;
      return w;
   endfunction

   // Stimulus: directed corner words first, then random words.
   initial begin
      logic signed [edv_pkg::DataWidth-1:0] a;
      logic signed [edv_pkg::DataWidth-1:0] b;
      pending_words.push_back(make_word(10, 3));
      pending_words.push_back(make_word(-10, 3));
      pending_words.push_back(make_word(10, -3));
      pending_words.push_back(make_word(-10, -3));
      pending_words.push_back(make_word(-9, 3));
      pending_words.push_back(make_word(-9, -3));
      pending_words.push_back(make_word(0, 5));
      pending_words.push_back(make_word(0, -5));
      pending_words.push_back(make_word(0, 0));
      pending_words.push_back(make_word(7, 0));
      pending_words.push_back(make_word(OpMin, 0));
      pending_words.push_back(make_word(OpMax, 0));
      pending_words.push_back(make_word(OpMin, -1));
      pending_words.push_back(make_word(OpMin, 1));
      pending_words.push_back(make_word(OpMin, OpMin));
      pending_words.push_back(make_word(OpMin, OpMax));
      pending_words.push_back(make_word(OpMax, OpMin));
      pending_words.push_back(make_word(OpMax, 1));
      pending_words.push_back(make_word(OpMax, -1));
      pending_words.push_back(make_word(OpMax, OpMax));
      pending_words.push_back(make_word(-1, OpMin));
      pending_words.push_back(make_word(-1, OpMax));
      pending_words.push_back(make_word(1, OpMin));
      pending_words.push_back(make_word(-1, 1));
      pending_words.push_back(make_word(OpMin + 1, 2));
      for (int i = 0; i < RandomWords; i++) begin
         b = draw_operand($urandom_range(0, 24) == 0);
         a = draw_operand(1'b1);
         // Exact multiples keep the zero-remainder path busy for both signs.
         if ($urandom_range(0, 7) == 0) a = b * ($urandom_range(0, 60) - 30);
         pending_words.push_back(make_word(a, b));
      end
      total_words = pending_words.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_accepted < total_words || expected_quotients.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog well past the slowest legal run.
   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Request driver: present the next word once the previous one is taken.
   int req_gap = 0;
   bit req_steady = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 149) == 0) req_steady = !req_steady;
            req_gap = draw_gap(req_steady);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls, plus two long holds to back up the pipe.
   int rsp_hold = 0;
   int long_holds = 0;
   bit rsp_steady = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_hold == 0 && long_holds < 2 && words_accepted >= 300 + 700 * long_holds) begin
            rsp_hold = 200;
            long_holds++;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 149) == 0) rsp_steady = !rsp_steady;
            rsp_hold = draw_gap(rsp_steady);
         end
      end
   end

   // Monitor: check each response word against the oldest expected quotient,
   // then record the quotient for any request word taken on this edge.
   always @(posedge clock) begin
      edv_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quotients.size() == 0) begin
            $error("unexpected response word: quotient %0d, divide_by_zero %0b",
                   rsp_data.quotient, rsp_data.divide_by_zero);
            mismatch_count++;
         end else begin
            want = expected_quotients.pop_front();
            if (rsp_data.quotient !== want.quotient) begin
               $error("quotient: expected %0d, actual %0d",
                      want.quotient, rsp_data.quotient);
               mismatch_count++;
            end
            if (rsp_data.divide_by_zero !== want.divide_by_zero) begin
               $error("divide_by_zero: expected %0b, actual %0b",
                      want.divide_by_zero, rsp_data.divide_by_zero);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         expected_quotients.push_back(euclid_quotient(req_data));
         words_accepted++;
      end
      req_taken <= !reset && req_valid && req_ready;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/edv_pkg.sv
rtl/edv_front.sv
rtl/edv_cell.sv
rtl/edv_back.sv
rtl/euclidean_integer_divider_top.sv
tb/sv/tb_top.sv
